/* design/stl_pkg.sv */
// Package for the script token lexer: token kind codes, keyword tables and
// the command, memory write and release structures passed between the parts.
// No dependencies.
`default_nettype none

package stl_pkg;

  localparam int TEXT_MAX_DEFAULT = 32;
  localparam int LEN_W            = 6;   // holds any text length up to 63
  localparam int KW_N             = 6;
  localparam int QDEPTH           = 4;

  localparam logic [4:0] K_EOF      = 5'd0;
  localparam logic [4:0] K_PUT      = 5'd1;
  localparam logic [4:0] K_IDENT    = 5'd7;
  localparam logic [4:0] K_NUM      = 5'd8;
  localparam logic [4:0] K_STR      = 5'd9;
  localparam logic [4:0] K_EQEQ     = 5'd10;
  localparam logic [4:0] K_LT       = 5'd14;
  localparam logic [4:0] K_GT       = 5'd15;
  localparam logic [4:0] K_SEMI     = 5'd16;
  localparam logic [4:0] K_LPAREN   = 5'd17;
  localparam logic [4:0] K_RPAREN   = 5'd18;
  localparam logic [4:0] K_LBRACE   = 5'd19;
  localparam logic [4:0] K_RBRACE   = 5'd20;
  localparam logic [4:0] K_BAD      = 5'd21;
  localparam logic [4:0] K_UNCLOSED = 5'd22;

  // One queued command: a single result, or a whole text token read from memory.
  typedef struct packed {
    logic [4:0]       kind;
    logic [7:0]       tbyte;
    logic             has_text;
    logic             run_end;
    logic [15:0]      line;
    logic             trunc;
    logic             is_text;
    logic [LEN_W-1:0] len;
    logic             bank;
  } cmd_t;

  typedef struct packed {
    logic v0;
    logic v1;
    cmd_t c0;
    cmd_t c1;
  } q_push_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LEN_W-1:0] idx;
    logic [7:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

  // Keywords, left-justified ASCII.
  function automatic logic [63:0] kw_word(input logic [2:0] k);
    logic [63:0] w;
    case (k)
      3'd0:    w = 64'h7075_7400_0000_0000;  // put
      3'd1:    w = 64'h6f6e_0000_0000_0000;  // on
      3'd2:    w = 64'h7368_6f77_5465_7874;  // showText
      3'd3:    w = 64'h7265_6164_5661_7200;  // readVar
      3'd4:    w = 64'h6966_0000_0000_0000;  // if
      3'd5:    w = 64'h7768_696c_6500_0000;  // while
      default: w = 64'h0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] k);
    logic [3:0] n;
    case (k)
      3'd0:    n = 4'd3;
      3'd1:    n = 4'd2;
      3'd2:    n = 4'd8;
      3'd3:    n = 4'd7;
      3'd4:    n = 4'd2;
      3'd5:    n = 4'd5;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
    logic [63:0] w;
    w = kw_word(k);
    return w[63 - 8*i -: 8];
  endfunction

endpackage

`default_nettype wire

/* design/stl_if.sv */
// Handshake channels of the lexer: character input and token result output.
// Depends on nothing.
`default_nettype none

interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface stl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [7:0]  text_byte;
  logic        has_text;
  logic        token_end;
  logic        run_end;
  logic [15:0] start_line;
  logic        truncated;
  modport source (output valid, output kind, output text_byte, output has_text,
                  output token_end, output run_end, output start_line,
                  output truncated, input ready);
  modport sink (input valid, input kind, input text_byte, input has_text,
                input token_end, input run_end, input start_line,
                input truncated, output ready);
endinterface

`default_nettype wire

/* design/script_token_lexer_unit.sv */
// Script token lexer, top level. Uses stl_pkg, stl_if, stl_front, stl_queue, stl_back.
// Throughput: one character a cycle while the queue has room; one result a cycle out
//   while the receiver is ready. Characters wait while the bank not being filled still
//   feeds an earlier token's text to the output, which can hold up scanning.
// Reset: asynchronous, active low; clears scanner, queue and output; text memory holds.
`default_nettype none

module script_token_lexer_unit #(
  parameter int TEXT_MAX = stl_pkg::TEXT_MAX_DEFAULT
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  stl_in_if.sink     src_i,
  stl_out_if.source  res_o
);
  import stl_pkg::*;

  // Front to queue, queue to back, and the text memory path between the ends.
  q_push_t push;
  cmd_t    head;
  logic    head_v;
  logic    pop;
  logic    free2;
  mem_wr_t wr;
  rel_t    rel;

  // Scanner: classify each character, push finished tokens as commands.
  stl_front #(
    .TEXT_MAX (TEXT_MAX)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (src_i),
    .q_free2_i (free2),
    .rel_i     (rel),
    .push_o    (push),
    .wr_o      (wr)
  );

  // Short queue: lets the scanner run on while results stall at the output.
  stl_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .head_o   (head),
    .head_v_o (head_v),
    .free2_o  (free2)
  );

  // Emitter: expand each command into results, reading token text from memory.
  stl_back #(
    .TEXT_MAX (TEXT_MAX)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .head_v_i (head_v),
    .pop_o    (pop),
    .wr_i     (wr),
    .rel_o    (rel),
    .out_o    (res_o)
  );

  // A character's last result always closes a token.
  a_run_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.run_end |-> res_o.token_end)
    else $error("run end on a result that does not close its token");

  // Only text tokens span several results, and every byte inside carries text.
  a_multi_is_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.token_end |->
      res_o.has_text &&
      (res_o.kind == K_IDENT || res_o.kind == K_NUM || res_o.kind == K_STR))
    else $error("open token result without text");

  // End of text is the last result of its character and carries nothing.
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind == K_EOF |-> res_o.run_end && !res_o.has_text)
    else $error("eof result not last or carries text");

  // Line numbers start at one.
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.start_line != 16'd0)
    else $error("result with line zero");

endmodule

`default_nettype wire

/* design/stl_front.sv */
// Front end of the lexer: accepts characters, runs the scanner state and
// pushes up to two commands per character. Uses stl_pkg and stl_in_if.
`default_nettype none

module stl_front #(
  parameter int TEXT_MAX = stl_pkg::TEXT_MAX_DEFAULT
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  stl_in_if.sink           in_i,
  input  wire              q_free2_i,
  input  stl_pkg::rel_t    rel_i,
  output stl_pkg::q_push_t push_o,
  output stl_pkg::mem_wr_t wr_o
);
  import stl_pkg::*;

  localparam int LW = $clog2(TEXT_MAX + 1);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUM     = 3'd2;
  localparam logic [2:0] MODE_STR     = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;
  localparam logic [2:0] MODE_OP      = 3'd5;

  localparam logic [1:0] PEND_EQ = 2'd0;
  localparam logic [1:0] PEND_GT = 2'd1;
  localparam logic [1:0] PEND_LT = 2'd2;
  localparam logic [1:0] PEND_NE = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [15:0] line_inc(input logic [15:0] l);
    return (l == 16'hffff) ? l : l + 16'd1;
  endfunction

  function automatic cmd_t mk_cmd(input logic [4:0] kind, input logic [7:0] b,
                                  input logic has, input logic [15:0] line);
    cmd_t c;
    c          = '0;
    c.kind     = kind;
    c.tbyte    = b;
    c.has_text = has;
    c.line     = line;
    return c;
  endfunction

  logic [2:0]    mode_q, mode_d;
  logic [1:0]    pend_q, pend_d;
  logic [LW-1:0] len_q, len_d;
  logic [KW_N-1:0] hits_q, hits_d;
  logic          ovf_q, ovf_d;
  logic [15:0]   cur_line_q, cur_line_d;
  logic [15:0]   tok_line_q, tok_line_d;
  logic          bank_q, bank_d;
  logic [1:0]    busy_q, busy_d;

  logic       acc;
  logic [7:0] ch;
  logic       f_v, s_v, do_idle, app, begin_tok, fin, eof, wr_en;
  logic [4:0] fin_kind;
  cmd_t       f_cmd, s_cmd;
  logic       kw_hit;
  logic [2:0] kw_sel;
  logic [LW-1:0] wr_idx;

  assign ch        = in_i.ch;
  assign in_i.ready = q_free2_i && !busy_q[~bank_q];
  assign acc       = in_i.valid && in_i.ready;

  // Keyword lookup on the finished identifier; lowest index wins.
  always_comb begin
    kw_hit = 1'b0;
    kw_sel = 3'd0;
    for (int k = KW_N - 1; k >= 0; k--) begin
      if (hits_q[k] && LEN_W'(len_q) == LEN_W'(kw_len(3'(k)))) begin
        kw_hit = 1'b1;
        kw_sel = 3'(k);
      end
    end
    kw_hit = kw_hit && !ovf_q;
  end

  always_comb begin
    mode_d     = mode_q;
    pend_d     = pend_q;
    len_d      = len_q;
    hits_d     = hits_q;
    ovf_d      = ovf_q;
    cur_line_d = cur_line_q;
    tok_line_d = tok_line_q;
    bank_d     = bank_q;
    busy_d     = busy_q;
    f_v        = 1'b0;
    f_cmd      = '0;
    s_v        = 1'b0;
    s_cmd      = '0;
    do_idle    = 1'b0;
    app        = 1'b0;
    begin_tok  = 1'b0;
    fin        = 1'b0;
    fin_kind   = K_IDENT;
    eof        = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = '0;

    // Continue the token in progress.
    case (mode_q)
      MODE_IDENT: begin
        if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDER) begin
          app = 1'b1;
        end else begin
          fin      = 1'b1;
          fin_kind = K_IDENT;
          do_idle  = 1'b1;
        end
      end
      MODE_NUM: begin
        if (is_digit(ch)) begin
          app = 1'b1;
        end else begin
          fin      = 1'b1;
          fin_kind = K_NUM;
          do_idle  = 1'b1;
        end
      end
      MODE_STR: begin
        if (ch == CH_QUOTE) begin
          fin      = 1'b1;
          fin_kind = K_STR;
        end else if (ch == CH_NUL) begin
          f_v     = 1'b1;
          f_cmd   = mk_cmd(K_UNCLOSED, 8'h00, 1'b0, tok_line_q);
          mode_d  = MODE_IDLE;
          do_idle = 1'b1;
        end else begin
          if (ch == CH_LF) cur_line_d = line_inc(cur_line_q);
          app = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (ch == CH_LF) begin
          cur_line_d = line_inc(cur_line_q);
          mode_d     = MODE_IDLE;
        end else if (ch == CH_NUL) begin
          mode_d  = MODE_IDLE;
          do_idle = 1'b1;
        end
      end
      MODE_OP: begin
        mode_d = MODE_IDLE;
        f_v    = 1'b1;
        if (ch == CH_EQ) begin
          f_cmd = mk_cmd(5'(K_EQEQ + pend_q), 8'h00, 1'b0, tok_line_q);
        end else begin
          do_idle = 1'b1;
          case (pend_q)
            PEND_EQ: f_cmd = mk_cmd(K_BAD, CH_EQ, 1'b1, tok_line_q);
            PEND_GT: f_cmd = mk_cmd(K_GT, 8'h00, 1'b0, tok_line_q);
            PEND_LT: f_cmd = mk_cmd(K_LT, 8'h00, 1'b0, tok_line_q);
            PEND_NE: f_cmd = mk_cmd(K_BAD, CH_BANG, 1'b1, tok_line_q);
            default: f_cmd = mk_cmd(K_BAD, CH_BANG, 1'b1, tok_line_q);
          endcase
        end
      end
      default: begin
        mode_d  = MODE_IDLE;
        do_idle = 1'b1;
      end
    endcase

    // Close a text token: keyword result or a text command for the back end.
    if (fin) begin
      mode_d = MODE_IDLE;
      f_v    = 1'b1;
      if (fin_kind == K_IDENT && kw_hit) begin
        f_cmd = mk_cmd(5'(K_PUT + kw_sel), 8'h00, 1'b0, tok_line_q);
      end else begin
        f_cmd         = mk_cmd(fin_kind, 8'h00, 1'b0, tok_line_q);
        f_cmd.trunc   = ovf_q;
        f_cmd.is_text = 1'b1;
        f_cmd.len     = LEN_W'(len_q);
        f_cmd.bank    = bank_q;
      end
    end

    // Scan the character from the idle state.
    if (do_idle) begin
      case (ch)
        CH_NUL: begin
          s_v   = 1'b1;
          s_cmd = mk_cmd(K_EOF, 8'h00, 1'b0, cur_line_q);
          eof   = 1'b1;
        end
        CH_LF:                              cur_line_d = line_inc(cur_line_q);
        CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR: ;
        CH_HASH:  mode_d = MODE_COMMENT;
        CH_QUOTE: begin
          begin_tok = 1'b1;
          mode_d    = MODE_STR;
        end
        CH_EQ, CH_GT, CH_LT, CH_BANG: begin
          mode_d     = MODE_OP;
          tok_line_d = cur_line_q;
          case (ch)
            CH_EQ:   pend_d = PEND_EQ;
            CH_GT:   pend_d = PEND_GT;
            CH_LT:   pend_d = PEND_LT;
            default: pend_d = PEND_NE;
          endcase
        end
        CH_SEMI:   begin s_v = 1'b1; s_cmd = mk_cmd(K_SEMI, 8'h00, 1'b0, cur_line_q);   end
        CH_LPAREN: begin s_v = 1'b1; s_cmd = mk_cmd(K_LPAREN, 8'h00, 1'b0, cur_line_q); end
        CH_RPAREN: begin s_v = 1'b1; s_cmd = mk_cmd(K_RPAREN, 8'h00, 1'b0, cur_line_q); end
        CH_LBRACE: begin s_v = 1'b1; s_cmd = mk_cmd(K_LBRACE, 8'h00, 1'b0, cur_line_q); end
        CH_RBRACE: begin s_v = 1'b1; s_cmd = mk_cmd(K_RBRACE, 8'h00, 1'b0, cur_line_q); end
        default: begin
          if (is_alpha(ch)) begin
            begin_tok = 1'b1;
            app       = 1'b1;
            mode_d    = MODE_IDENT;
          end else if (is_digit(ch)) begin
            begin_tok = 1'b1;
            app       = 1'b1;
            mode_d    = MODE_NUM;
          end else begin
            s_v   = 1'b1;
            s_cmd = mk_cmd(K_BAD, ch, 1'b1, cur_line_q);
          end
        end
      endcase
    end

    // New token text goes to the other bank.
    if (begin_tok) begin
      len_d      = '0;
      hits_d     = '1;
      ovf_d      = 1'b0;
      bank_d     = ~bank_q;
      tok_line_d = cur_line_q;
    end

    if (app) begin
      if (len_d < LW'(TEXT_MAX)) begin
        for (int k = 0; k < KW_N; k++) begin
          if (!(LEN_W'(len_d) < LEN_W'(kw_len(3'(k))) &&
                kw_char(3'(k), len_d[2:0]) == ch)) begin
            hits_d[k] = 1'b0;
          end
        end
        wr_en  = 1'b1;
        wr_idx = len_d;
        len_d  = len_d + LW'(1);
      end else begin
        ovf_d  = 1'b1;
        hits_d = '0;
      end
    end

    // End of text puts the scanner back to its reset state; the text bank is kept.
    if (eof) begin
      mode_d     = MODE_IDLE;
      pend_d     = PEND_EQ;
      len_d      = '0;
      hits_d     = '1;
      ovf_d      = 1'b0;
      cur_line_d = 16'd1;
      tok_line_d = 16'd1;
    end

    if (rel_i.en) busy_d[rel_i.bank] = 1'b0;
    if (acc && fin && f_cmd.is_text) busy_d[bank_q] = 1'b1;
  end

  // Pack the commands into queue slots; flag the last one of this character.
  always_comb begin
    push_o    = '0;
    push_o.v0 = acc && (f_v || s_v);
    push_o.v1 = acc && f_v && s_v;
    push_o.c0 = f_v ? f_cmd : s_cmd;
    push_o.c1 = s_cmd;
    if (f_v && s_v) push_o.c1.run_end = 1'b1;
    else            push_o.c0.run_end = 1'b1;
  end

  assign wr_o.en   = acc && wr_en;
  assign wr_o.bank = bank_d;
  assign wr_o.idx  = LEN_W'(wr_idx);
  assign wr_o.data = ch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      pend_q     <= PEND_EQ;
      len_q      <= '0;
      hits_q     <= '1;
      ovf_q      <= 1'b0;
      cur_line_q <= 16'd1;
      tok_line_q <= 16'd1;
      bank_q     <= 1'b0;
      busy_q     <= '0;
    end else begin
      busy_q <= busy_d;
      if (acc) begin
        mode_q     <= mode_d;
        pend_q     <= pend_d;
        len_q      <= len_d;
        hits_q     <= hits_d;
        ovf_q      <= ovf_d;
        cur_line_q <= cur_line_d;
        tok_line_q <= tok_line_d;
        bank_q     <= bank_d;
      end
    end
  end

endmodule

`default_nettype wire

/* design/stl_queue.sv */
// Command queue between the lexer front and back ends: two pushes, one pop.
// Uses stl_pkg.
`default_nettype none

module stl_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  stl_pkg::q_push_t push_i,
  input  wire              pop_i,
  output stl_pkg::cmd_t    head_o,
  output logic             head_v_o,
  output logic             free2_o
);
  import stl_pkg::*;

  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  cmd_t           entry_q [QDEPTH];
  logic [QAW-1:0] wptr_q, rptr_q;
  logic [QCW-1:0] cnt_q;
  logic [QAW-1:0] wptr_nx;
  logic [QCW-1:0] n_push;

  assign wptr_nx  = wptr_q + QAW'(1);
  assign n_push   = QCW'(push_i.v0) + QCW'(push_i.v1);
  assign head_o   = entry_q[rptr_q];
  assign head_v_o = cnt_q != '0;
  assign free2_o  = cnt_q <= QCW'(QDEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.v0) entry_q[wptr_q] <= push_i.c0;
    if (push_i.v1) entry_q[wptr_nx] <= push_i.c1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + QAW'(n_push);
      if (pop_i) rptr_q <= rptr_q + QAW'(1);
      cnt_q <= cnt_q + n_push - QCW'(pop_i);
    end
  end

endmodule

`default_nettype wire

/* design/stl_back.sv */
// Back end of the lexer: takes commands from the queue, reads token text from
// the two-bank text memory and drives the result register. Uses stl_pkg, stl_out_if.
`default_nettype none

module stl_back #(
  parameter int TEXT_MAX = stl_pkg::TEXT_MAX_DEFAULT
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  stl_pkg::cmd_t    head_i,
  input  wire              head_v_i,
  output logic             pop_o,
  input  stl_pkg::mem_wr_t wr_i,
  output stl_pkg::rel_t    rel_o,
  stl_out_if.source        out_o
);
  import stl_pkg::*;

  localparam int IW = $clog2(TEXT_MAX);
  localparam int AW = IW + 1;

  logic [7:0] text_mem [2**AW];

  cmd_t          cur_q;
  logic          cur_v_q;
  logic [IW-1:0] idx_q;
  logic          text_mode, last, adv;

  logic        out_v_q;
  logic [4:0]  kind_q;
  logic [7:0]  tbyte_q, rd_q;
  logic        sel_mem_q, has_q, tend_q, rend_q, trunc_q;
  logic [15:0] line_q;

  assign text_mode = cur_q.is_text && cur_q.len != '0;
  assign last      = !text_mode || (LEN_W'(idx_q) == cur_q.len - LEN_W'(1));
  assign adv       = cur_v_q && (!out_v_q || out_o.ready);
  assign pop_o     = head_v_i && (!cur_v_q || (adv && last));

  // Release the text bank once its last byte has been read.
  assign rel_o.en   = adv && last && cur_q.is_text;
  assign rel_o.bank = cur_q.bank;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) text_mem[{wr_i.bank, wr_i.idx[IW-1:0]}] <= wr_i.data;
    if (adv) rd_q <= text_mem[{cur_q.bank, idx_q}];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
    if (adv) begin
      kind_q    <= cur_q.kind;
      tbyte_q   <= cur_q.tbyte;
      sel_mem_q <= text_mode;
      has_q     <= text_mode || cur_q.has_text;
      tend_q    <= last;
      rend_q    <= last && cur_q.run_end;
      line_q    <= cur_q.line;
      trunc_q   <= cur_q.trunc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (adv) idx_q <= last ? '0 : idx_q + IW'(1);
      if (pop_o)            cur_v_q <= 1'b1;
      else if (adv && last) cur_v_q <= 1'b0;
      if (adv)              out_v_q <= 1'b1;
      else if (out_o.ready) out_v_q <= 1'b0;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.kind       = kind_q;
  assign out_o.text_byte  = sel_mem_q ? rd_q : tbyte_q;
  assign out_o.has_text   = has_q;
  assign out_o.token_end  = tend_q;
  assign out_o.run_end    = rend_q;
  assign out_o.start_line = line_q;
  assign out_o.truncated  = trunc_q;

endmodule

`default_nettype wire

/* bench/stl_token_checker.sv */
// Token checker for the script token lexer: predicts the results of every
// accepted character transaction and compares them with what the block emits.
// Depends on stl_pkg and the stl_in_if / stl_out_if channel interfaces.
module stl_token_checker #(
  parameter int TEXT_MAX = stl_pkg::TEXT_MAX_DEFAULT
) (
  input  wire clk_i,
  input  wire rst_ni,
  stl_in_if   src_i,
  stl_out_if  res_i,
  output int  fail_count_o,
  output int  pending_o
);
  import stl_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_IDENT, SCAN_NUM, SCAN_STR, SCAN_COMMENT, SCAN_OP
  } scan_e;

  // First character of a two-character operator; its code offsets K_EQEQ.
  localparam logic [1:0] OP_EQ  = 2'd0;
  localparam logic [1:0] OP_GT  = 2'd1;
  localparam logic [1:0] OP_LT  = 2'd2;
  localparam logic [1:0] OP_NOT = 2'd3;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  text_byte;
    logic        has_text;
    logic        token_end;
    logic        run_end;
    logic [15:0] start_line;
    logic        truncated;
  } token_res_t;

  scan_e       mode;
  logic [1:0]  op_code;
  logic [7:0]  text_buf [TEXT_MAX];
  int          text_len;
  logic        text_cut;
  logic [15:0] line_now;
  logic [15:0] line_tok;
  token_res_t  burst [$];
  token_res_t  expected_tokens [$];
  int          mismatches;

  task automatic clear_scan();
    mode     = SCAN_IDLE;
    op_code  = OP_EQ;
    text_len = 0;
    text_cut = 1'b0;
    line_now = 16'd1;
    line_tok = 16'd1;
  endtask

  task automatic put_res(input logic [4:0] kind, input logic [7:0] data, input logic has,
                         input logic last, input logic [15:0] line, input logic cut);
    burst.push_back({kind, data, has, last, 1'b0, line, cut});
  endtask

  task automatic bump_line();
    if (line_now != 16'hFFFF) line_now++;
  endtask

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic open_text(input scan_e m);
    mode     = m;
    line_tok = line_now;
    text_len = 0;
    text_cut = 1'b0;
  endtask

  task automatic add_byte(input logic [7:0] c);
    if (text_len < TEXT_MAX) begin
      text_buf[text_len] = c;
      text_len++;
    end else begin
      text_cut = 1'b1;
    end
  endtask

  function automatic int keyword_index();
    string words [6];
    bit same;
    words = '{"put", "on", "showText", "readVar", "if", "while"};
    for (int k = 0; k < 6; k++) begin
      if (words[k].len() == text_len) begin
        same = 1'b1;
        for (int i = 0; i < text_len; i++)
          if (words[k][i] != text_buf[i]) same = 1'b0;
        if (same) return k;
      end
    end
    return -1;
  endfunction

  task automatic close_text(input logic [4:0] kind);
    int kw;
    kw = -1;
    if (kind == K_IDENT && !text_cut) kw = keyword_index();
    if (kw >= 0) begin
      put_res(K_PUT + 5'(kw), 8'h00, 1'b0, 1'b1, line_tok, 1'b0);
    end else if (text_len == 0) begin
      put_res(kind, 8'h00, 1'b0, 1'b1, line_tok, text_cut);
    end else begin
      for (int i = 0; i < text_len; i++)
        put_res(kind, text_buf[i], 1'b1, i + 1 == text_len, line_tok, text_cut);
    end
    mode = SCAN_IDLE;
  endtask

  // A character seen with no token open.
  task automatic scan_fresh(input logic [7:0] c);
    case (c)
      CH_NUL: begin
        put_res(K_EOF, 8'h00, 1'b0, 1'b1, line_now, 1'b0);
        clear_scan();
      end
      "\n": bump_line();
      " ", "\t", CH_VT, CH_FF, "\r": begin
      end
      "#": mode = SCAN_COMMENT;
      "\"": open_text(SCAN_STR);
      "=", ">", "<", "!": begin
        case (c)
          "=":     op_code = OP_EQ;
          ">":     op_code = OP_GT;
          "<":     op_code = OP_LT;
          default: op_code = OP_NOT;
        endcase
        mode     = SCAN_OP;
        line_tok = line_now;
      end
      ";": put_res(K_SEMI, 8'h00, 1'b0, 1'b1, line_now, 1'b0);
      "(": put_res(K_LPAREN, 8'h00, 1'b0, 1'b1, line_now, 1'b0);
      ")": put_res(K_RPAREN, 8'h00, 1'b0, 1'b1, line_now, 1'b0);
      "{": put_res(K_LBRACE, 8'h00, 1'b0, 1'b1, line_now, 1'b0);
      "}": put_res(K_RBRACE, 8'h00, 1'b0, 1'b1, line_now, 1'b0);
      default: begin
        if (is_letter(c)) begin
          open_text(SCAN_IDENT);
          add_byte(c);
        end else if (is_digit(c)) begin
          open_text(SCAN_NUM);
          add_byte(c);
        end else begin
          put_res(K_BAD, c, 1'b1, 1'b1, line_now, 1'b0);
        end
      end
    endcase
  endtask

  task automatic lex_char(input logic [7:0] c);
    burst.delete();
    case (mode)
      SCAN_IDENT: begin
        if (is_letter(c) || is_digit(c) || c == "_") begin
          add_byte(c);
        end else begin
          close_text(K_IDENT);
          scan_fresh(c);
        end
      end
      SCAN_NUM: begin
        if (is_digit(c)) begin
          add_byte(c);
        end else begin
          close_text(K_NUM);
          scan_fresh(c);
        end
      end
      SCAN_STR: begin
        if (c == "\"") begin
          close_text(K_STR);
        end else if (c == CH_NUL) begin
          put_res(K_UNCLOSED, 8'h00, 1'b0, 1'b1, line_tok, 1'b0);
          mode = SCAN_IDLE;
          scan_fresh(c);
        end else begin
          if (c == "\n") bump_line();
          add_byte(c);
        end
      end
      SCAN_COMMENT: begin
        if (c == "\n") begin
          bump_line();
          mode = SCAN_IDLE;
        end else if (c == CH_NUL) begin
          mode = SCAN_IDLE;
          scan_fresh(c);
        end
      end
      SCAN_OP: begin
        mode = SCAN_IDLE;
        if (c == "=") begin
          put_res(K_EQEQ + {3'b000, op_code}, 8'h00, 1'b0, 1'b1, line_tok, 1'b0);
        end else begin
          case (op_code)
            OP_EQ:   put_res(K_BAD, "=", 1'b1, 1'b1, line_tok, 1'b0);
            OP_GT:   put_res(K_GT, 8'h00, 1'b0, 1'b1, line_tok, 1'b0);
            OP_LT:   put_res(K_LT, 8'h00, 1'b0, 1'b1, line_tok, 1'b0);
            default: put_res(K_BAD, "!", 1'b1, 1'b1, line_tok, 1'b0);
          endcase
          scan_fresh(c);
        end
      end
      default: scan_fresh(c);
    endcase
    if (burst.size() > 0) burst[burst.size() - 1].run_end = 1'b1;
    foreach (burst[i]) expected_tokens.push_back(burst[i]);
  endtask

  task automatic check_result(input token_res_t got);
    token_res_t want;
    if (expected_tokens.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("unexpected token result: kind %0d byte %02h text %0b end %0b run %0b line %0d trunc %0b",
                 got.kind, got.text_byte, got.has_text, got.token_end, got.run_end,
                 got.start_line, got.truncated);
      return;
    end
    want = expected_tokens.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("token mismatch, expected: kind %0d byte %02h text %0b end %0b run %0b line %0d trunc %0b",
                 want.kind, want.text_byte, want.has_text, want.token_end, want.run_end,
                 want.start_line, want.truncated);
        $display("token mismatch, actual:   kind %0d byte %02h text %0b end %0b run %0b line %0d trunc %0b",
                 got.kind, got.text_byte, got.has_text, got.token_end, got.run_end,
                 got.start_line, got.truncated);
      end
    end
  endtask

  // Results are compared before the character of the same edge is predicted:
  // a character's results never leave on the edge that accepts it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      expected_tokens.delete();
      mismatches = 0;
    end else begin
      if (res_i.valid && res_i.ready)
        check_result({res_i.kind, res_i.text_byte, res_i.has_text, res_i.token_end,
                      res_i.run_end, res_i.start_line, res_i.truncated});
      if (src_i.valid && src_i.ready) lex_char(src_i.ch);
    end
    pending_o    = expected_tokens.size();
    fail_count_o = mismatches;
  end

endmodule

/* bench/tb.sv */
// Testbench top for the script token lexer: clock, reset, character stimulus
// and the verdict. Depends on stl_pkg, stl_in_if, stl_out_if, the lexer
// top level and stl_token_checker.
module tb;
  import stl_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TAIL_CYCLES  = 20;
  localparam int PHASE_ITEMS  = 40;

  // Classes of generated token; each random token is drawn from one of these.
  localparam int TC_KEYWORD   = 0;
  localparam int TC_IDENT     = 1;
  localparam int TC_NUMBER    = 2;
  localparam int TC_STRING    = 3;
  localparam int TC_OP_PAIR   = 4;
  localparam int TC_OP_SINGLE = 5;
  localparam int TC_OP_LONE   = 6;
  localparam int TC_COMMENT   = 7;
  localparam int TC_NOISE     = 8;
  localparam int TC_END       = 9;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;

  logic       clk;
  logic       rst_n;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         cycles = 0;
  int         fail_count;
  int         pending;
  logic [7:0] chunk [$];
  string      keyword_text [6] = '{"put", "on", "showText", "readVar", "if", "while"};

  stl_in_if  in_ch ();
  stl_out_if out_ch ();

  script_token_lexer_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .src_i  (in_ch),
    .res_o  (out_ch)
  );

  stl_token_checker #(
    .TEXT_MAX (TEXT_MAX_DEFAULT)
  ) token_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .src_i        (in_ch),
    .res_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: a correct run finishes far inside this bound, even with
  // every long token stalled by the receiver.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver side: drop ready at random, at the rate of the current phase.
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic logic [7:0] letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? "a" : "A";
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] ident_char();
    case ($urandom_range(0, 3))
      0:       return "_";
      1:       return digit();
      default: return letter();
    endcase
  endfunction

  // Any non-zero byte but the one given: string bodies and comment bodies.
  function automatic logic [7:0] byte_except(input logic [7:0] banned);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == banned);
    return c;
  endfunction

  // Present one character and hold it until the block takes the transaction.
  // The sender may idle first, at the rate of the current phase.
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.ch    = c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender until every predicted result has been taken.
  task automatic drain();
    in_ch.valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  // One phase of random text: well-formed tokens with random content, some
  // noise bytes and broken tokens, whitespace between most of them. With
  // walk set, the first tokens step through every class once in order.
  task automatic run_phase(input int sp, input int rp, input bit walk);
    int    count;
    int    n;
    int    cls;
    int    k;
    bit    lengthy;
    string pairs [4];
    string singles;
    pairs   = '{"==", ">=", "<=", "!="};
    singles = "<>;(){}";
    send_idle_pct = sp;
    recv_idle_pct = rp;
    count = 0;
    n     = 0;
    while (count < PHASE_ITEMS) begin
      cls     = (walk && n <= TC_END) ? n : $urandom_range(TC_KEYWORD, TC_END);
      lengthy = ($urandom_range(0, 7) == 0);
      case (cls)
        TC_KEYWORD: begin
          k = $urandom_range(0, 5);
          for (int i = 0; i < keyword_text[k].len(); i++) chunk.push_back(keyword_text[k][i]);
          // Sometimes extend it into a plain identifier that starts like a keyword.
          if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) chunk.push_back(ident_char());
        end
        TC_IDENT: begin
          chunk.push_back(letter());
          repeat (lengthy ? $urandom_range(30, 39) : $urandom_range(0, 9))
            chunk.push_back(ident_char());
        end
        TC_NUMBER: begin
          repeat (lengthy ? $urandom_range(31, 40) : $urandom_range(1, 6))
            chunk.push_back(digit());
        end
        TC_STRING: begin
          chunk.push_back("\"");
          // Empty strings, short ones, and ones around the text limit.
          k = lengthy ? $urandom_range(31, 40)
                      : ($urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 8));
          repeat (k) chunk.push_back(byte_except("\""));
          chunk.push_back("\"");
        end
        TC_OP_PAIR: begin
          k = $urandom_range(0, 3);
          chunk.push_back(pairs[k][0]);
          chunk.push_back(pairs[k][1]);
        end
        TC_OP_SINGLE: chunk.push_back(singles[$urandom_range(0, 6)]);
        TC_OP_LONE:   chunk.push_back($urandom_range(0, 1) ? "=" : "!");
        TC_COMMENT: begin
          chunk.push_back("#");
          repeat ($urandom_range(0, 10)) chunk.push_back(byte_except("\n"));
          chunk.push_back("\n");
        end
        TC_NOISE: chunk.push_back(8'($urandom_range(1, 255)));
        default: begin
          // End of text, now and then straight after an unclosed string.
          if ($urandom_range(0, 2) == 0) begin
            chunk.push_back("\"");
            repeat ($urandom_range(0, 4)) chunk.push_back(byte_except("\""));
          end
          chunk.push_back(CH_NUL);
        end
      endcase
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       chunk.push_back(" ");
          1:       chunk.push_back("\t");
          2:       chunk.push_back(CH_VT);
          3:       chunk.push_back(CH_FF);
          4:       chunk.push_back("\r");
          default: chunk.push_back("\n");
        endcase
      end
      count += chunk.size();
      while (chunk.size() > 0) send_byte(chunk.pop_front());
      n++;
    end
    // Close the text so the next phase starts from a clean line count.
    send_byte(CH_NUL);
    drain();
  endtask

  initial begin
    logic [7:0] directed [$];
    in_ch.valid   = 1'b0;
    in_ch.ch      = CH_NUL;
    out_ch.ready  = 1'b0;
    rst_n         = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 55;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening: bad bytes at both ends of the range and '_', a lone
    // '=' and a lone '!' each followed by a token, an empty string, >= and <,
    // a string left open across a newline at end of text, a comment closed by
    // end of text, and a number closed by end of text.
    directed = '{"_", 8'hFF, 8'h80, 8'h01, "=", ";", "!", "x", " ",
                 "\"", "\"", ">", "=", "<", "\n",
                 "\"", "\n", "a", CH_NUL,
                 "#", "z", CH_NUL, "9", CH_NUL};
    foreach (directed[i]) send_byte(directed[i]);
    drain();

    run_phase(19, 55, 1'b1);
    run_phase(55, 19, 1'b0);
    run_phase(0, 0, 1'b0);

    // Close with a short text back to back: a token, a semicolon and end of text.
    send_byte("a");
    send_byte(";");
    send_byte(CH_NUL);

    in_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/stl_pkg.sv
design/stl_if.sv
design/stl_front.sv
design/stl_queue.sv
design/stl_back.sv
design/script_token_lexer_unit.sv
bench/stl_token_checker.sv
bench/tb.sv
